>>> src/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants for the frustum box cull block
// Formats, pipeline depth and the item record that moves along the plane cells.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int AXES        = 3;
  localparam int CORNER_W    = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_W       = 64;

  // Corner product: 17-bit sum times 16-bit scale, Q8.8 fraction dropped by a shift.
  localparam int PROD_W      = 33;
  localparam int FRAC_SHIFT  = 8;
  localparam int SAT_MAX     = 32767;
  localparam int SAT_MIN     = -32768;

  // Plane test: Q2.14 normal times Q12.4 corner, three terms summed.
  localparam int TERM_W      = 32;
  localparam int DOT_W       = 34;
  localparam int DIST_SHIFT  = 14;
  localparam int DIST_LSB    = 48;

  // Input register, product, corner, then two stages per plane cell.
  localparam int LATENCY     = 3 + 2 * PLANE_COUNT;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     plane_word_t;

  typedef struct packed {
    logic                             outside;
    logic [AXES-1:0][CORNER_W-1:0]    lo;
    logic [AXES-1:0][CORNER_W-1:0]    hi;
  } fbc_item_t;

endpackage

>>> src/fbc_corner.sv
// ----------------------------------------------------------------------------
// fbc_corner: one box corner moved and scaled
// Two stages: (corner + pos) * scale, then floor to Q12.4 and saturate.
// ----------------------------------------------------------------------------
module fbc_corner (
  input  logic                                clk,
  input  logic signed [fbc_pkg::CORNER_W-1:0] corner_i,
  input  logic signed [fbc_pkg::CORNER_W-1:0] pos_i,
  input  logic signed [fbc_pkg::CORNER_W-1:0] scale_i,
  output logic signed [fbc_pkg::CORNER_W-1:0] corner_o
);
  import fbc_pkg::*;

  logic signed [CORNER_W:0]            sum;
  logic signed [PROD_W-1:0]            prod_nxt;
  logic signed [PROD_W-1:0]            prod_r;
  logic signed [PROD_W-FRAC_SHIFT-1:0] quot;
  logic signed [CORNER_W-1:0]          corner_nxt;
  logic signed [CORNER_W-1:0]          corner_r;

  always_comb begin
    sum      = $signed({corner_i[CORNER_W-1], corner_i}) + $signed({pos_i[CORNER_W-1], pos_i});
    prod_nxt = sum * scale_i;
  end

  // Dropping the low fraction bits of a two's complement value rounds toward minus infinity.
  always_comb begin
    quot = prod_r[PROD_W-1:FRAC_SHIFT];
    if (quot > SAT_MAX) begin
      corner_nxt = CORNER_W'(SAT_MAX);
    end else if (quot < SAT_MIN) begin
      corner_nxt = CORNER_W'(SAT_MIN);
    end else begin
      corner_nxt = quot[CORNER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    corner_r <= corner_nxt;
  end

  assign corner_o = corner_r;

endmodule

>>> src/fbc_plane_cell.sv
// ----------------------------------------------------------------------------
// fbc_plane_cell: one frustum plane of the culling chain
// Holds one plane word and tests each passing box against it in two stages.
// ----------------------------------------------------------------------------
module fbc_plane_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr,
  input  fbc_pkg::plane_word_t cfg_wdata,
  input  logic                 vld_i,
  input  fbc_pkg::fbc_item_t   item_i,
  output logic                 vld_o,
  output fbc_pkg::fbc_item_t   item_o
);
  import fbc_pkg::*;

  plane_word_t              plane_r;
  logic signed [TERM_W-1:0] term_nxt [AXES];
  logic signed [TERM_W-1:0] term_r   [AXES];
  logic                     vld_a_r;
  fbc_item_t                item_a_r;
  logic signed [DOT_W-1:0]  dot;
  logic signed [DOT_W-1:0]  thr;
  logic signed [CORNER_W-1:0] plane_dist;
  fbc_item_t                item_nxt;
  fbc_item_t                item_b_r;
  logic                     vld_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_wr) begin
      plane_r <= cfg_wdata;
    end
  end

  // n*s + |n|*e collapses to 2*n*max for a positive normal and 2*n*min for a
  // negative one, so each axis needs one product and both sides drop the factor 2.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (plane_r[CORNER_W*a + CORNER_W-1]) begin
        term_nxt[a] = $signed(plane_r[CORNER_W*a +: CORNER_W]) * $signed(item_i.lo[a]);
      end else begin
        term_nxt[a] = $signed(plane_r[CORNER_W*a +: CORNER_W]) * $signed(item_i.hi[a]);
      end
    end
  end

  always_comb begin
    plane_dist = $signed(plane_r[DIST_LSB +: CORNER_W]);
    dot  = DOT_W'(term_r[0]) + DOT_W'(term_r[1]) + DOT_W'(term_r[2]);
    thr  = -(DOT_W'(plane_dist) <<< DIST_SHIFT);
    item_nxt         = item_a_r;
    item_nxt.outside = item_a_r.outside | (dot < thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_i;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    term_r   <= term_nxt;
    item_a_r <= item_i;
    item_b_r <= item_nxt;
  end

  assign vld_o  = vld_b_r;
  assign item_o = item_b_r;

`ifndef SYNTHESIS
  a_outside_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_i && item_i.outside) |=> ##1 item_o.outside)
    else $error("outside flag cleared by a later plane cell");

  a_valid_passes: assert property (@(posedge clk) disable iff (!rst_n)
    vld_a_r |=> vld_o)
    else $error("box lost between the two stages of a plane cell");
`endif

endmodule

>>> src/frustum_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_box_cull: six-plane view-frustum culling of axis-aligned boxes
// Moves and scales each box corner, then tests the box against six programmed planes.
// ----------------------------------------------------------------------------
// One box is taken per clock cycle whenever start is high; busy is always low.
// The verdict appears on out_outside with out_valid once the transfer has passed
// through one input register, two stages for the corner multiply and
// saturation, then a chain of six plane cells of two stages each (product, then
// sum and compare). Results cannot be held off. Plane words must be written
// while no box is in flight.
module frustum_box_cull (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_box_min_x,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_box_min_y,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_box_min_z,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_box_max_x,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_box_max_y,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_box_max_z,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_pos_x,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_pos_y,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_pos_z,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_scale_x,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_scale_y,
  input  logic signed [fbc_pkg::CORNER_W-1:0] in_scale_z,
  output logic                                out_valid,
  output logic                                out_outside,
  input  logic                                cfg_we,
  input  fbc_pkg::cfg_idx_t                   cfg_index,
  input  fbc_pkg::plane_word_t                cfg_wdata
);
  import fbc_pkg::*;

  logic                       in_vld_r;
  logic signed [CORNER_W-1:0] min_r   [AXES];
  logic signed [CORNER_W-1:0] max_r   [AXES];
  logic signed [CORNER_W-1:0] pos_r   [AXES];
  logic signed [CORNER_W-1:0] scale_r [AXES];
  logic signed [CORNER_W-1:0] lo_c    [AXES];
  logic signed [CORNER_W-1:0] hi_c    [AXES];
  logic                       prod_vld_r;
  logic                       corner_vld_r;
  logic                       vld_chain  [PLANE_COUNT+1];
  fbc_item_t                  item_chain [PLANE_COUNT+1];

  // Every stage advances each cycle, so a new box is always welcome.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      prod_vld_r   <= 1'b0;
      corner_vld_r <= 1'b0;
    end else begin
      in_vld_r     <= start & ~busy;
      prod_vld_r   <= in_vld_r;
      corner_vld_r <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    min_r[0]   <= in_box_min_x;
    min_r[1]   <= in_box_min_y;
    min_r[2]   <= in_box_min_z;
    max_r[0]   <= in_box_max_x;
    max_r[1]   <= in_box_max_y;
    max_r[2]   <= in_box_max_z;
    pos_r[0]   <= in_pos_x;
    pos_r[1]   <= in_pos_y;
    pos_r[2]   <= in_pos_z;
    scale_r[0] <= in_scale_x;
    scale_r[1] <= in_scale_y;
    scale_r[2] <= in_scale_z;
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    fbc_corner u_lo (
      .clk      (clk),
      .corner_i (min_r[a]),
      .pos_i    (pos_r[a]),
      .scale_i  (scale_r[a]),
      .corner_o (lo_c[a])
    );

    fbc_corner u_hi (
      .clk      (clk),
      .corner_i (max_r[a]),
      .pos_i    (pos_r[a]),
      .scale_i  (scale_r[a]),
      .corner_o (hi_c[a])
    );

    assign item_chain[0].lo[a] = lo_c[a];
    assign item_chain[0].hi[a] = hi_c[a];
  end

  assign item_chain[0].outside = 1'b0;
  assign vld_chain[0]          = corner_vld_r;

  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
    logic plane_wr;

    assign plane_wr = cfg_we && (cfg_index == cfg_idx_t'(k));

    fbc_plane_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg_wr    (plane_wr),
      .cfg_wdata (cfg_wdata),
      .vld_i     (vld_chain[k]),
      .item_i    (item_chain[k]),
      .vld_o     (vld_chain[k+1]),
      .item_o    (item_chain[k+1])
    );
  end

  assign out_valid   = vld_chain[PLANE_COUNT];
  assign out_outside = item_chain[PLANE_COUNT].outside;

`ifndef SYNTHESIS
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a box transfer at the fixed latency");

  a_box_reaches_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##2 vld_chain[0])
    else $error("accepted box did not reach the plane chain");
`endif

endmodule
